>>> hw/rtl/u8dw_pkg.sv
// ----------------------------------------------------------------------------
// u8dw_pkg
// Shared types for the UTF-8 display width core: the input and result
// transactions and the decoded token passed from front to back.
// ----------------------------------------------------------------------------
package u8dw_pkg;

    localparam int CP_W    = 21;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic [1:0]      cell_width;
        logic [31:0]     running_cells;
        logic            text_done;
    } t_out_item;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            last;
    } t_token;

endpackage

>>> hw/rtl/u8dw_front.sv
// ----------------------------------------------------------------------------
// u8dw_front
// Byte-level UTF-8 decoder. Tracks the open sequence and emits one token
// with the finished code point and the end-of-text flag.
// ----------------------------------------------------------------------------
module u8dw_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  u8dw_pkg::t_in_item  i_item,
    output logic                o_tok_valid,
    output u8dw_pkg::t_token    o_tok
);
    import u8dw_pkg::*;

    logic [7:0]  r_lead,     n_lead;
    logic [2:0]  r_expected, n_expected;
    logic [2:0]  r_seen,     n_seen;
    logic [17:0] r_payload,  n_payload;
    logic        r_malf,     n_malf;

    logic [7:0]  b;
    logic        last;
    logic [2:0]  claim;
    logic [2:0]  seen_inc;
    logic [17:0] pay_inc;
    logic        malf_inc;
    logic [CP_W-1:0] decoded;

    function automatic logic [2:0] claim_of(input logic [7:0] v);
        logic [2:0] n;
        n = 3'd1;
        if (v[7] == 1'b0) begin
            n = 3'd1;
        end else if (v[7:5] == 3'b110) begin
            n = 3'd2;
        end else if (v[7:4] == 4'b1110) begin
            n = 3'd3;
        end else if (v[7:3] == 5'b11110) begin
            n = 3'd4;
        end
        return n;
    endfunction

    always_comb begin
        b        = i_item.text_byte;
        last     = i_item.end_of_text;
        claim    = claim_of(b);
        seen_inc = r_seen + 3'd1;
        pay_inc  = {r_payload[11:0], b[5:0]};
        malf_inc = r_malf | (b[7:6] != 2'b10);
        unique case (seen_inc)
            3'd2:    decoded = {10'd0, r_lead[4:0], pay_inc[5:0]};
            3'd3:    decoded = {5'd0, r_lead[3:0], pay_inc[11:0]};
            default: decoded = {r_lead[2:0], pay_inc};
        endcase

        n_lead      = r_lead;
        n_expected  = r_expected;
        n_seen      = r_seen;
        n_payload   = r_payload;
        n_malf      = r_malf;
        o_tok_valid = 1'b0;
        o_tok.code_point = CP_W'(b);
        o_tok.last       = last;

        if (i_accept) begin
            if (r_expected == 3'd0) begin
                n_lead = b;
                if (claim > 3'd1 && !last) begin
                    n_expected = claim;
                    n_seen     = 3'd1;
                    n_payload  = '0;
                    n_malf     = 1'b0;
                end else begin
                    o_tok_valid = 1'b1;
                end
            end else if (seen_inc < r_expected && !last) begin
                n_seen    = seen_inc;
                n_payload = pay_inc;
                n_malf    = malf_inc;
            end else begin
                o_tok_valid      = 1'b1;
                o_tok.code_point = malf_inc ? CP_W'(r_lead) : decoded;
                n_expected       = '0;
                n_seen           = '0;
                n_payload        = '0;
                n_malf           = 1'b0;
            end
            if (last) begin
                n_expected = '0;
                n_seen     = '0;
                n_payload  = '0;
                n_malf     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead     <= '0;
            r_expected <= '0;
            r_seen     <= '0;
            r_payload  <= '0;
            r_malf     <= 1'b0;
        end else begin
            r_lead     <= n_lead;
            r_expected <= n_expected;
            r_seen     <= n_seen;
            r_payload  <= n_payload;
            r_malf     <= n_malf;
        end
    end

endmodule

>>> hw/rtl/u8dw_queue.sv
// ----------------------------------------------------------------------------
// u8dw_queue
// Small token queue between decoder and width stage, head shown
// combinationally.
// ----------------------------------------------------------------------------
module u8dw_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  u8dw_pkg::t_token    i_tok,
    input  logic                i_rd,
    output u8dw_pkg::t_token    o_head,
    output logic                o_empty,
    output logic                o_full
);
    import u8dw_pkg::*;

    localparam logic [Q_AW:0] DEPTH = (Q_AW+1)'(Q_DEPTH);

    t_token          r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_AW:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == DEPTH);
    assign o_head  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slot[r_wptr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full && !i_rd))
        else $error("token written into full queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr && !i_rd |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not follow write");

endmodule

>>> hw/rtl/u8dw_back.sv
// ----------------------------------------------------------------------------
// u8dw_back
// Cell width lookup, saturating running total and result register.
// ----------------------------------------------------------------------------
module u8dw_back #(
    parameter int TOTAL_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  u8dw_pkg::t_token    i_head,
    output logic                o_q_rd,
    input  logic                i_pop,
    output logic                o_empty,
    output u8dw_pkg::t_out_item o_result
);
    import u8dw_pkg::*;

    localparam int SUM_W = TOTAL_BITS + 1;

    typedef struct packed {
        logic [CP_W-1:0] lo;
        logic [CP_W-1:0] hi;
    } t_span;

    localparam t_span ZERO_SPANS [9] = '{
        '{21'h00300, 21'h0036F}, '{21'h01AB0, 21'h01AFF}, '{21'h01DC0, 21'h01DFF},
        '{21'h0200B, 21'h0200F}, '{21'h02060, 21'h02064}, '{21'h020D0, 21'h020FF},
        '{21'h0FE00, 21'h0FE0F}, '{21'h0FE20, 21'h0FE2F}, '{21'hE0100, 21'hE01EF}};

    localparam t_span WIDE_SPANS [63] = '{
        '{21'h01100, 21'h0115F}, '{21'h0231A, 21'h0231B}, '{21'h02329, 21'h0232A},
        '{21'h023E9, 21'h023EC}, '{21'h023F0, 21'h023F0}, '{21'h023F3, 21'h023F3},
        '{21'h025FD, 21'h025FE}, '{21'h02614, 21'h02615}, '{21'h02648, 21'h02653},
        '{21'h0267F, 21'h0267F}, '{21'h02693, 21'h02693}, '{21'h026A1, 21'h026A1},
        '{21'h026AA, 21'h026AB}, '{21'h026BD, 21'h026BE}, '{21'h026C4, 21'h026C5},
        '{21'h026CE, 21'h026CE}, '{21'h026D4, 21'h026D4}, '{21'h026EA, 21'h026EA},
        '{21'h026F2, 21'h026F3}, '{21'h026F5, 21'h026F5}, '{21'h026FA, 21'h026FA},
        '{21'h026FD, 21'h026FD}, '{21'h02705, 21'h02705}, '{21'h0270A, 21'h0270B},
        '{21'h02728, 21'h02728}, '{21'h0274C, 21'h0274C}, '{21'h0274E, 21'h0274E},
        '{21'h02753, 21'h02755}, '{21'h02757, 21'h02757}, '{21'h02795, 21'h02797},
        '{21'h027B0, 21'h027B0}, '{21'h027BF, 21'h027BF}, '{21'h02B1B, 21'h02B1C},
        '{21'h02B50, 21'h02B50}, '{21'h02B55, 21'h02B55}, '{21'h02E80, 21'h0303E},
        '{21'h03041, 21'h033FF}, '{21'h03400, 21'h04DBF}, '{21'h04E00, 21'h09FFF},
        '{21'h0A000, 21'h0A4CF}, '{21'h0A960, 21'h0A97F}, '{21'h0AC00, 21'h0D7A3},
        '{21'h0F900, 21'h0FAFF}, '{21'h0FE10, 21'h0FE19}, '{21'h0FE30, 21'h0FE6F},
        '{21'h0FF00, 21'h0FF60}, '{21'h0FFE0, 21'h0FFE6}, '{21'h16FE0, 21'h16FE4},
        '{21'h17000, 21'h18CFF}, '{21'h1B000, 21'h1B2FF}, '{21'h1F004, 21'h1F004},
        '{21'h1F0CF, 21'h1F0CF}, '{21'h1F18E, 21'h1F18E}, '{21'h1F191, 21'h1F19A},
        '{21'h1F200, 21'h1F2FF}, '{21'h1F300, 21'h1F64F}, '{21'h1F680, 21'h1F6FF},
        '{21'h1F7E0, 21'h1F7EB}, '{21'h1F7F0, 21'h1F7F0}, '{21'h1F90C, 21'h1F9FF},
        '{21'h1FA70, 21'h1FAFF}, '{21'h20000, 21'h2FFFD}, '{21'h30000, 21'h3FFFD}};

    logic                  r_valid;
    t_out_item             r_out;
    logic [TOTAL_BITS-1:0] r_total;

    logic                  take;
    logic [8:0]            zero_hit;
    logic [62:0]           wide_hit;
    logic [1:0]            width;
    logic [SUM_W-1:0]      sum;
    logic [TOTAL_BITS-1:0] new_total;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            zero_hit[i] = (i_head.code_point >= ZERO_SPANS[i].lo) &&
                          (i_head.code_point <= ZERO_SPANS[i].hi);
        end
        for (int i = 0; i < 63; i++) begin
            wide_hit[i] = (i_head.code_point >= WIDE_SPANS[i].lo) &&
                          (i_head.code_point <= WIDE_SPANS[i].hi);
        end
        if (|zero_hit) begin
            width = 2'd0;
        end else if (|wide_hit) begin
            width = 2'd2;
        end else begin
            width = 2'd1;
        end
    end

    assign take      = !i_q_empty && (!r_valid || i_pop);
    assign o_q_rd    = take;
    assign sum       = {1'b0, r_total} + SUM_W'(width);
    assign new_total = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
    assign o_empty   = !r_valid;
    assign o_result  = r_out;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.code_point    <= i_head.code_point;
            r_out.cell_width    <= width;
            r_out.running_cells <= 32'(new_total);
            r_out.text_done     <= i_head.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_total <= '0;
        end else if (take) begin
            r_valid <= 1'b1;
            r_total <= i_head.last ? '0 : new_total;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    a_total_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_head.last |=> r_total == '0)
        else $error("running total not cleared after end of text");

    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_out.cell_width != 2'd3)
        else $error("illegal cell width");

endmodule

>>> hw/rtl/utf8_display_width_core.sv
// ----------------------------------------------------------------------------
// utf8_display_width_core
// Streaming UTF-8 decoder that reports each code point with its terminal
// cell width and the saturating running cell total of the current text.
// ----------------------------------------------------------------------------
// One text byte is taken every cycle while full is low. A decoder front end
// turns bytes into code points and drops them into a four-entry queue; the
// back end looks up the cell width with parallel range compares, adds it to
// the running total (saturating at 2^TOTAL_BITS-1) and holds the result in
// an output register. A token completed by an accepted byte is written to the
// queue at that edge and moves to the output register once that is free; full
// rises only when four results are backed up behind an unpopped output. The
// total and any open sequence are cleared after the result with text_done.
module utf8_display_width_core #(
    parameter int TOTAL_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  u8dw_pkg::t_in_item  i_text,
    output logic                empty,
    input  logic                pop,
    output u8dw_pkg::t_out_item o_result
);
    import u8dw_pkg::*;

    logic   accept;
    logic   tok_valid;
    t_token tok;
    t_token head;
    logic   q_empty;
    logic   q_rd;

    assign accept = push && !full;

    u8dw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_text),
        .o_tok_valid (tok_valid),
        .o_tok       (tok)
    );

    u8dw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (tok_valid),
        .i_tok   (tok),
        .i_rd    (q_rd),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (full)
    );

    u8dw_back #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (head),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule
